>>> sv/ile_pkg.sv
// Shared constants, codes and types of the indexed list engine.
package ile_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Capacity);
  localparam int unsigned CntW      = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic signed [DataWidth-1:0] value;
    logic signed [15:0]          position;
  } req_t;

  typedef struct packed {
    status_e                     status;
    logic signed [DataWidth-1:0] read_value;
    logic [CntW-1:0]             list_length;
  } res_t;

endpackage

>>> sv/ile_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module ile_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ile_seq.sv
// Sequencer that runs insert, delete and read requests over the entry RAM.
module ile_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  ile_pkg::req_t                  req_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  input  logic                           res_take_i,
  output ile_pkg::res_t                  res_o,
  output logic                           ram_we_o,
  output logic [ile_pkg::AddrW-1:0]      ram_waddr_o,
  output logic [ile_pkg::DataWidth-1:0]  ram_wdata_o,
  output logic [ile_pkg::AddrW-1:0]      ram_raddr_o,
  input  logic [ile_pkg::DataWidth-1:0]  ram_rdata_i
);
  import ile_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_INS_PUT   = 7'b0000100,
    S_DEL_SCAN  = 7'b0001000,
    S_DEL_SHIFT = 7'b0010000,
    S_RD_WAIT   = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      ptr_q, ptr_d;
  logic [AddrW-1:0]      idx_q, idx_d;
  logic [DataWidth-1:0]  val_q, val_d;
  status_e               status_q, status_d;
  logic [DataWidth-1:0]  rdata_q, rdata_d;

  logic                  pos_neg;
  logic [14:0]           pos_mag;
  logic [14:0]           cnt_ext;
  logic [CntW-1:0]       pos_low;
  logic [CntW-1:0]       ins_idx;
  logic [CntW-1:0]       rd_idx;
  logic [CntW-1:0]       ptr_inc;
  logic                  more;

  assign pos_neg = req_i.position[15];
  assign pos_mag = req_i.position[14:0];
  assign cnt_ext = 15'(count_q);
  assign pos_low = req_i.position[CntW-1:0];

  // Clamp the requested index into the list.
  assign ins_idx = pos_neg ? '0 : ((pos_mag > cnt_ext) ? count_q : pos_low);
  assign rd_idx  = pos_neg ? '0 : ((pos_mag >= cnt_ext) ? (count_q - 1'b1) : pos_low);

  // Shared step unit: next scan address and whether it is still inside the list.
  assign ptr_inc = {1'b0, ptr_q} + 1'b1;
  assign more    = ptr_inc < count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d    = req_i.value;
          status_d = ST_OK;
          rdata_d  = '0;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (count_q == CntW'(Capacity)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                idx_d = AddrW'(ins_idx);
                if (ins_idx == count_q) begin
                  state_d = S_INS_PUT;
                end else begin
                  ram_raddr_o = AddrW'(count_q - 1'b1);
                  ptr_d       = AddrW'(count_q - 1'b1);
                  state_d     = S_INS_SHIFT;
                end
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                ram_raddr_o = '0;
                ptr_d       = '0;
                state_d     = S_DEL_SCAN;
              end
            end
            REQ_READ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                ram_raddr_o = AddrW'(rd_idx);
                state_d     = S_RD_WAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        // The word read last cycle moves up one place while the next one is read.
        ram_we_o    = 1'b1;
        ram_waddr_o = AddrW'(ptr_inc);
        ram_wdata_o = ram_rdata_i;
        if (ptr_q > idx_q) begin
          ram_raddr_o = ptr_q - 1'b1;
          ptr_d       = ptr_q - 1'b1;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = val_q;
        count_d     = count_q + 1'b1;
        state_d     = S_DONE;
      end
      S_DEL_SCAN: begin
        if (ram_rdata_i == val_q) begin
          if (more) begin
            ram_raddr_o = AddrW'(ptr_inc);
            ptr_d       = AddrW'(ptr_inc);
            state_d     = S_DEL_SHIFT;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_DONE;
          end
        end else if (more) begin
          ram_raddr_o = AddrW'(ptr_inc);
          ptr_d       = AddrW'(ptr_inc);
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_DEL_SHIFT: begin
        // The word read last cycle moves down one place.
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q - 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (more) begin
          ram_raddr_o = AddrW'(ptr_inc);
          ptr_d       = AddrW'(ptr_inc);
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_RD_WAIT: begin
        rdata_d = ram_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  assign busy_o            = state_q != S_IDLE;
  assign res_valid_o       = state_q == S_DONE;
  assign res_o.status      = status_q;
  assign res_o.read_value  = rdata_q;
  assign res_o.list_length = count_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count exceeds capacity");

  a_count_moves_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == S_DONE))
    else $error("entry count changed outside request completion");

  a_start_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (state_q != S_IDLE))
    else $error("accepted item did not start the sequencer");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == S_INS_SHIFT || state_q == S_INS_PUT ||
                  state_q == S_DEL_SHIFT))
    else $error("RAM written outside a shift or insert step");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ST_FULL) |-> (count_q == CntW'(Capacity)))
    else $error("full status reported on a list that is not full");

endmodule

>>> sv/indexed_list_engine_core.sv
// Top level of the indexed list engine: handshakes, sequencer, RAM and result register.
// A read waits for the RAM; an insert shifts the tail up one place, then writes; a delete
// scans for the value and shifts the rest down; a rejected request (full insert, empty
// read or delete, unused code) goes straight to done. One entry moves per cycle, and
// the next item can be taken in the cycle after the result enters the output register.
// Reset (rst_ni low, asynchronous) empties the list and clears both handshakes only.
module indexed_list_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [31:0]          value_i,
  input  logic signed [15:0]          position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          read_value_o,
  output logic [6:0]                  list_length_o
);
  import ile_pkg::*;

  logic                  busy;
  logic                  start;
  req_t                  req;
  logic                  res_valid;
  logic                  res_take;
  res_t                  res;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [DataWidth-1:0]  ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  logic [DataWidth-1:0]  ram_rdata;
  logic                  out_valid_q;
  res_t                  out_res_q;

  // The sequencer takes a new item only while it is idle.
  assign in_stall_o   = busy;
  assign start        = in_valid_i && !busy;
  assign req.req_type = req_type_i;
  assign req.value    = value_i;
  assign req.position = position_i;

  // A finished result moves into the output register once that register is free or
  // is being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  ile_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ile_ram #(
    .Depth (Capacity),
    .Width (DataWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign read_value_o  = out_res_q.read_value;
  assign list_length_o = out_res_q.list_length;

endmodule

>>> tb/tb_indexed_list_engine_core.sv
// Self-checking testbench for the indexed list engine: random and directed requests.
`timescale 1ns / 1ps

module tb_indexed_list_engine_core;
  import ile_pkg::*;

  // A stretch of this many clock cycles in which neither channel moves an item counts as a hang.
  localparam int unsigned HangCycles = 2000;
  localparam int unsigned MaxShown   = 10;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  // Keeps the expected list contents and the queue of results still owed by the block.
  class list_scoreboard;
    logic signed [DataWidth-1:0] entries[$];
    res_t                        owed[$];
    int                          errors;

    function void note_request(req_t r);
      res_t e;
      int   n;
      int   pos;
      int   idx;
      n   = entries.size();
      pos = $signed(r.position);
      idx = -1;
      e.status     = ST_OK;
      e.read_value = '0;
      case (req_e'(r.req_type))
        REQ_INSERT: begin
          if (n >= Capacity) begin
            e.status = ST_FULL;
          end else begin
            // Negative positions land at the head, positions past the end append.
            idx = (pos < 0) ? 0 : ((pos > n) ? n : pos);
            entries.insert(idx, r.value);
          end
        end
        REQ_DELETE: begin
          foreach (entries[i]) begin
            if (idx < 0 && entries[i] == r.value) idx = i;
          end
          if (idx < 0) begin
            e.status = ST_NOT_FOUND;
          end else begin
            entries.delete(idx);
          end
        end
        REQ_READ: begin
          if (n == 0) begin
            e.status = ST_EMPTY;
          end else begin
            idx = (pos < 0) ? 0 : ((pos >= n) ? n - 1 : pos);
            e.read_value = entries[idx];
          end
        end
        default: begin
        end
      endcase
      e.list_length = CntW'(entries.size());
      owed.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (owed.size() == 0) begin
        if (errors < MaxShown) begin
          $display("%0t: unexpected result status=%0d read_value=%0d list_length=%0d",
                   $realtime, got.status, got.read_value, got.list_length);
        end
        errors++;
      end else begin
        e = owed.pop_front();
        if (got.status !== e.status || got.read_value !== e.read_value ||
            got.list_length !== e.list_length) begin
          if (errors < MaxShown) begin
            $display("%0t: mismatch status %0d/%0d read_value %0d/%0d list_length %0d/%0d",
                     $realtime, got.status, e.status, got.read_value, e.read_value,
                     got.list_length, e.list_length);
            $display("  (values shown as actual/expected)");
          end
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i = '0;
  logic signed [31:0]   value_i = '0;
  logic signed [15:0]   position_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic signed [31:0]   read_value_o;
  logic [6:0]           list_length_o;

  list_scoreboard sb;
  bit             steady_in;
  bit             steady_out;

  indexed_list_engine_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Drives one item after a random gap, none while steady_in is set, and books it once taken.
  // Valid is only ever raised or lowered once per falling edge.
  task automatic send_item(input req_t r);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= r.req_type;
    value_i    <= r.value;
    position_i <= r.position;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic send_req(input req_e op, input logic signed [31:0] v,
                          input logic signed [15:0] p);
    req_t r;
    r.req_type = op;
    r.value    = v;
    r.position = p;
    send_item(r);
  endtask

  // Holds the sender back until every booked result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return 32'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_position(int n);
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(n);
      3:       return 16'(n + 1);
      4:       return 16'($urandom);
      5:       return 16'(-int'($urandom_range(1, 5)));
      default: return 16'($urandom_range(0, n));
    endcase
  endfunction

  // Fill phases mostly insert, drain phases mostly delete values that are present,
  // and mixed phases blend everything with some unused codes as noise.
  function automatic req_t make_item(phase_e kind);
    req_t r;
    int   n;
    int   roll;
    bit   hit;
    n    = sb.entries.size();
    roll = $urandom_range(0, 99);
    hit  = 1'b0;
    r.value    = pick_value();
    r.position = pick_position(n);
    case (kind)
      PH_FILL: begin
        if (roll < 80)      r.req_type = REQ_INSERT;
        else if (roll < 88) r.req_type = REQ_READ;
        else if (roll < 95) r.req_type = REQ_DELETE;
        else                r.req_type = REQ_NONE;
      end
      PH_DRAIN: begin
        r.req_type = REQ_DELETE;
        hit = (roll < 75);
        if (roll >= 85 && roll < 95) r.req_type = REQ_READ;
        else if (roll >= 95)         r.req_type = REQ_INSERT;
      end
      default: begin
        if (roll < 35)      r.req_type = REQ_INSERT;
        else if (roll < 70) r.req_type = REQ_DELETE;
        else if (roll < 92) r.req_type = REQ_READ;
        else                r.req_type = REQ_NONE;
        hit = (roll >= 35 && roll < 60);
      end
    endcase
    if (hit && n > 0) r.value = sb.entries[$urandom_range(0, n - 1)];
    return r;
  endfunction

  // Result side: a random stall before each result unless steady_out is set, then taken as soon as it shows.
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = steady_out ? 0 : $urandom_range(0, 12);
      repeat (wait_cycles) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status      = status_e'(status_o);
      got.read_value  = read_value_o;
      got.list_length = list_length_o;
      sb.check_result(got);
    end
  end

  // Hang detection: counts cycles in which neither channel moves an item.
  initial begin
    int idle;
    idle = 0;
    while (idle < HangCycles) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("tb_indexed_list_engine_core: errors");
    $finish;
  end

  initial begin
    phase_e plan[6];
    int     count;
    int     extra;
    sb   = new();
    plan = '{PH_FILL, PH_DRAIN, PH_MIXED, PH_FILL, PH_MIXED, PH_DRAIN};
    steady_in  = 1'b0;
    steady_out = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: read, delete and the unused code.
    send_req(REQ_READ, 32'sd0, 16'sd0);
    send_req(REQ_DELETE, 32'sd5, 16'sd0);
    send_req(REQ_NONE, -32'sd1, -16'sd1);
    // Inserts with clamped positions, at the head, the tail and the middle.
    send_req(REQ_INSERT, 32'sh7fff_ffff, 16'sh8000);
    send_req(REQ_INSERT, 32'sh8000_0000, 16'sh7fff);
    send_req(REQ_INSERT, 32'sd0, 16'sd1);
    send_req(REQ_INSERT, -32'sd1, 16'sd0);
    send_req(REQ_INSERT, 32'sd7, 16'sd2);
    send_req(REQ_INSERT, 32'sd7, 16'sh7fff);
    // Reads below, past, at and inside the list.
    send_req(REQ_READ, 32'sd0, 16'sh8000);
    send_req(REQ_READ, 32'sd0, 16'sh7fff);
    send_req(REQ_READ, 32'sd0, 16'sd6);
    send_req(REQ_READ, 32'sd0, 16'sd5);
    send_req(REQ_READ, 32'sd0, 16'sd2);
    // A duplicate value loses only its first copy.
    send_req(REQ_DELETE, 32'sd7, 16'sd0);
    send_req(REQ_READ, 32'sd0, 16'sd2);
    send_req(REQ_DELETE, 32'sd12345, 16'sd0);
    send_req(REQ_DELETE, 32'sh8000_0000, 16'sd0);
    send_req(REQ_DELETE, 32'sh7fff_ffff, 16'sd0);
    send_req(REQ_NONE, 32'sh5555_aaaa, 16'sh7fff);
    send_req(REQ_DELETE, 32'sd0, 16'sd0);
    send_req(REQ_DELETE, -32'sd1, 16'sd0);
    send_req(REQ_DELETE, 32'sd7, 16'sd0);
    send_req(REQ_READ, 32'sd0, 16'sd100);
    send_req(REQ_INSERT, 32'sd3, -16'sd1);
    drain_results();

    // Fill and drain phases run until the list is full or empty three times, or 150 items
    // are sent, so full inserts and empty reads come up with random content around them.
    foreach (plan[p]) begin
      steady_in  = (p == 3 || p == 4);
      steady_out = (p == 2 || p == 3);
      count = 0;
      extra = 0;
      while (extra < 3 && count < 150) begin
        send_item(make_item(plan[p]));
        count++;
        if (plan[p] == PH_FILL && sb.entries.size() == Capacity) extra++;
        if (plan[p] == PH_DRAIN && sb.entries.size() == 0) extra++;
        if (plan[p] == PH_MIXED && count >= 50) extra = 3;
      end
      drain_results();
    end

    // Every result has arrived; any stray one that shows before the final check counts as an error.
    repeat (20) @(posedge clk_i);
    if (sb.owed.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("tb_indexed_list_engine_core: clean");
    end else begin
      $display("tb_indexed_list_engine_core: errors");
    end
    $finish;
  end

endmodule
